// ----- hw/rtl/gsp_pkg.sv -----
// Shared types, constants and fixed log2 / exp2 interpolation tables
// for the gas sensor ppm estimator. No dependencies.
`default_nettype none

package gsp_pkg;

   localparam int ADC_FULL_SCALE = 2047;
   localparam int SAMPLE_W       = 11;
   localparam int RES_W          = 22;
   localparam int RO_W           = 24;
   localparam int PPM_W          = 16;
   localparam int CNT_W          = 8;
   localparam int SUM_W          = 32;
   localparam int RES_SCALE      = 1280;
   localparam int LOG10_OF_2     = 19728;
   localparam int LOG2_OF_10     = 217707;

   localparam int LOG_DEPTH = 64;
   localparam int IDX_W     = $clog2(LOG_DEPTH);
   localparam int TAB_W     = 18;

   localparam int DIV_NUM_W = 40;
   localparam int DIV_DEN_W = 24;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   typedef logic [TAB_W-1:0] tab_type [0:LOG_DEPTH];

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_rsp_type;

   function automatic longint unsigned gsp_isqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bval;
      longint unsigned w;
      res  = 0;
      w    = v;
      bval = 64'd1 << 62;
      while (bval > w) bval = bval >> 2;
      while (bval != 0) begin
         if (w >= res + bval) begin
            w   = w - (res + bval);
            res = (res >> 1) + bval;
         end else begin
            res = res >> 1;
         end
         bval = bval >> 2;
      end
      return res;
   endfunction

   function automatic tab_type gsp_log_tab();
      tab_type         tab;
      longint unsigned m;
      longint unsigned r;
      int              i;
      int              b;
      for (i = 0; i < LOG_DEPTH; i++) begin
         m = (64'd1 << 30) + ((64'(i) << 30) / LOG_DEPTH);
         r = 0;
         for (b = 0; b < 20; b++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               r = r | 64'd1;
            end
         end
         tab[i] = TAB_W'((r + 64'd8) >> 4);
      end
      tab[LOG_DEPTH] = TAB_W'(65536);
      return tab;
   endfunction

   function automatic tab_type gsp_exp_tab();
      tab_type         tab;
      longint unsigned roots [20];
      longint unsigned acc;
      longint unsigned f20;
      int              i;
      int              b;
      roots[0] = gsp_isqrt(64'd2 << 60);
      for (b = 1; b < 20; b++) roots[b] = gsp_isqrt(roots[b-1] << 30);
      for (i = 0; i < LOG_DEPTH; i++) begin
         f20 = (64'(i) << 20) / LOG_DEPTH;
         acc = 64'd1 << 30;
         for (b = 0; b < 20; b++) begin
            if (((f20 >> (19 - b)) & 64'd1) != 0) acc = (acc * roots[b]) >> 30;
         end
         tab[i] = TAB_W'((acc + 64'd8192) >> 14);
      end
      tab[LOG_DEPTH] = TAB_W'(131072);
      return tab;
   endfunction

   localparam tab_type LOG_TAB = gsp_log_tab();
   localparam tab_type EXP_TAB = gsp_exp_tab();

endpackage

`default_nettype wire

// ----- hw/rtl/gsp_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on gsp_pkg for widths and the request / response structs.
`default_nettype none

module gsp_div import gsp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output      div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] nq_ff, nq_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in, rem_sh;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic                 ge;

   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], nq_ff[DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      nq_in   = nq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         nq_in   = req.num;
         rem_in  = '0;
         den_in  = req.den;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sh - {1'b0, den_ff} : rem_sh;
         nq_in  = {nq_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      nq_ff  <= nq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quot = nq_ff;

   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff) else $error("divider started while busy");

   a_start_runs: assert property (@(posedge clock) disable iff (reset)
      req.start |=> busy_ff && !done_ff) else $error("divider did not start");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff) && !busy_ff) else $error("divider done without a run");

endmodule

`default_nettype wire

// ----- hw/rtl/gas_sensor_ppm_estimator_unit.sv -----
// Gas sensor ppm estimator top level: sequencer, run accumulators, log/exp path.
// Depends on gsp_pkg and gsp_div.
//
// Each beat on req_ carries one raw sample. Samples are turned into a sensor
// resistance and summed per run; the last sample of a calibration run yields a
// new Ro, the last of a measurement run yields a ppm estimate on rsp_. One
// item is handled at a time and req_ready is low while it is in work. All
// divisions go through one shared 40-step bit-serial divider. A sample that
// does not close a run needs one division (none for a sample of zero or full
// scale), one that closes a calibration run up to three, one that closes a
// measurement run up to four plus up to 23 normalize steps. A measurement
// sample before any calibration is dropped without a result. A finished
// result waits in the rsp_ register; the next item is taken meanwhile and
// stalls only if it too must deliver.
`default_nettype none

module gas_sensor_ppm_estimator_unit import gsp_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   input  wire logic                req_func,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   input  wire logic [1:0]          req_gas,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      logic                rsp_kind,
   output      logic [RO_W-1:0]     rsp_ro_kohm,
   output      logic [PPM_W-1:0]    rsp_ppm,
   output      logic                rsp_saturated,
   input  wire logic                csr_write_en,
   input  wire logic [2:0]          csr_index,
   input  wire logic [47:0]         csr_wdata
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_RDIV   = 4'd1;
   localparam logic [3:0] ST_ACCUM  = 4'd2;
   localparam logic [3:0] ST_AVG    = 4'd3;
   localparam logic [3:0] ST_RODIV  = 4'd4;
   localparam logic [3:0] ST_RATDIV = 4'd5;
   localparam logic [3:0] ST_RCHK   = 4'd6;
   localparam logic [3:0] ST_NORM   = 4'd7;
   localparam logic [3:0] ST_LOG1   = 4'd8;
   localparam logic [3:0] ST_LOG2   = 4'd9;
   localparam logic [3:0] ST_EGO    = 4'd10;
   localparam logic [3:0] ST_EDIV   = 4'd11;
   localparam logic [3:0] ST_EXP1   = 4'd12;
   localparam logic [3:0] ST_EXP2   = 4'd13;
   localparam logic [3:0] ST_EXP3   = 4'd14;
   localparam logic [3:0] ST_DONE   = 4'd15;

   localparam logic [2:0] CSR_CALIB_TGT = 3'd0;
   localparam logic [2:0] CSR_READ_TGT  = 3'd1;
   localparam logic [2:0] CSR_CAF       = 3'd2;
   localparam logic [2:0] CSR_LPG       = 3'd3;
   localparam logic [2:0] CSR_CO        = 3'd4;
   localparam logic [2:0] CSR_SMOKE     = 3'd5;

   localparam logic [1:0] GAS_LPG   = 2'd0;
   localparam logic [1:0] GAS_CO    = 2'd1;
   localparam logic [1:0] GAS_SMK   = 2'd2;
   localparam logic [1:0] GAS_NONE  = 2'd3;

   localparam logic [RES_W-1:0] RES_MAX = '1;
   localparam logic [RO_W-1:0]  Q24_MAX = '1;

   // configuration
   logic [CNT_W-1:0] calib_tgt_ff, read_tgt_ff;
   logic [15:0]      caf_ff;
   logic [47:0]      lpg_ff, co_ff, smoke_ff;

   // control
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] calib_count_ff, calib_count_in, read_count_ff, read_count_in;
   logic [SUM_W-1:0] calib_sum_ff, calib_sum_in, read_sum_ff, read_sum_in;
   logic [RO_W-1:0]  ro_ff, ro_in;
   logic             calibrated_ff, calibrated_in;
   logic             calib_sat_ff, calib_sat_in, read_sat_ff, read_sat_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // working payload
   logic                    func_ff, func_in;
   logic [1:0]              gas_ff, gas_in;
   logic [RES_W-1:0]        res_ff, res_in;
   logic [RO_W-1:0]         norm_ff, norm_in;
   logic [4:0]              msb_ff, msb_in;
   logic signed [21:0]      l2_ff, l2_in;
   logic signed [19:0]      l10_ff, l10_in;
   logic                    eneg_ff, eneg_in;
   logic signed [22:0]      e_ff, e_in;
   logic signed [24:0]      t_ff, t_in;
   logic [TAB_W-1:0]        v_ff, v_in;
   logic [PPM_W-1:0]        ppm_ff, ppm_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   logic [RO_W-1:0]         rsp_ro_ff, rsp_ro_in;
   logic [PPM_W-1:0]        rsp_ppm_ff, rsp_ppm_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // helpers
   logic [47:0]             curve_sel;
   logic signed [15:0]      cx, cy, cslope;
   logic [CNT_W-1:0]        tgt_raw, tgt, count_cur, count_new;
   logic [SUM_W-1:0]        sum_cur, sum_new;
   logic [RES_W-1:0]        avg;
   logic [15:0]             lfrac, lfr, efrac, efr;
   logic [IDX_W:0]          lidx, eidx;
   logic [TAB_W-1:0]        ldiff, ediff, linterp, einterp;
   logic [TAB_W+15:0]       lprod, eprod;
   logic signed [5:0]       lexp;
   logic signed [37:0]      l10_prod;
   logic signed [20:0]      ydiff;
   logic signed [32:0]      enum_s;
   logic [32:0]             emag;
   logic [15:0]             smag;
   logic signed [34:0]      qs, e35;
   logic signed [41:0]      t_prod;
   logic signed [8:0]       kexp, kshift;
   logic [TAB_W-1:0]        pshift;

   gsp_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      case (gas_ff)
         GAS_LPG:   curve_sel = lpg_ff;
         GAS_CO:    curve_sel = co_ff;
         GAS_SMK:   curve_sel = smoke_ff;
         default:   curve_sel = '0;
      endcase
   end

   assign cx     = $signed(curve_sel[47:32]);
   assign cy     = $signed(curve_sel[31:16]);
   assign cslope = $signed(curve_sel[15:0]);

   assign tgt_raw   = func_ff ? read_tgt_ff : calib_tgt_ff;
   assign tgt       = (tgt_raw == '0) ? CNT_W'(1) : tgt_raw;
   assign count_cur = func_ff ? read_count_ff : calib_count_ff;
   assign sum_cur   = func_ff ? read_sum_ff : calib_sum_ff;
   assign count_new = count_cur + 1'b1;
   assign sum_new   = sum_cur + SUM_W'(res_ff);
   assign avg       = div_rsp.quot[RES_W-1:0];

   // log2 mantissa interpolation
   assign lfrac   = norm_ff[22:7];
   assign lidx    = {1'b0, lfrac[15 -: IDX_W]};
   assign lfr     = {lfrac[15-IDX_W:0], {IDX_W{1'b0}}};
   assign ldiff   = LOG_TAB[lidx + 1'b1] - LOG_TAB[lidx];
   assign lprod   = ldiff * lfr;
   assign linterp = LOG_TAB[lidx] + lprod[TAB_W+15:16];
   assign lexp    = $signed({1'b0, msb_ff}) - 6'sd16;

   assign l10_prod = l2_ff * $signed(16'(LOG10_OF_2));

   assign ydiff  = $signed({l10_ff[19], l10_ff}) - $signed({cy[15], cy, 4'b0});
   assign enum_s = $signed({ydiff, 12'b0});
   assign emag   = ydiff[20] ? 33'(-enum_s) : 33'(enum_s);
   assign smag   = cslope[15] ? 16'(-cslope) : 16'(cslope);

   assign qs  = eneg_ff ? -$signed({2'b0, div_rsp.quot[32:0]})
                        :  $signed({2'b0, div_rsp.quot[32:0]});
   assign e35 = qs + $signed({{15{cx[15]}}, cx, 4'b0});

   assign t_prod = e_ff * $signed(19'(LOG2_OF_10));

   // exp2 fraction interpolation
   assign efrac   = t_ff[15:0];
   assign eidx    = {1'b0, efrac[15 -: IDX_W]};
   assign efr     = {efrac[15-IDX_W:0], {IDX_W{1'b0}}};
   assign ediff   = EXP_TAB[eidx + 1'b1] - EXP_TAB[eidx];
   assign eprod   = ediff * efr;
   assign einterp = EXP_TAB[eidx] + eprod[TAB_W+15:16];

   assign kexp   = t_ff[24:16];
   assign kshift = 9'sd16 - kexp;
   assign pshift = v_ff >> kshift[5:0];

   always_comb begin
      state_in       = state_ff;
      calib_count_in = calib_count_ff;
      calib_sum_in   = calib_sum_ff;
      read_count_in  = read_count_ff;
      read_sum_in    = read_sum_ff;
      ro_in          = ro_ff;
      calibrated_in  = calibrated_ff;
      calib_sat_in   = calib_sat_ff;
      read_sat_in    = read_sat_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      func_in        = func_ff;
      gas_in         = gas_ff;
      res_in         = res_ff;
      norm_in        = norm_ff;
      msb_in         = msb_ff;
      l2_in          = l2_ff;
      l10_in         = l10_ff;
      eneg_in        = eneg_ff;
      e_in           = e_ff;
      t_in           = t_ff;
      v_in           = v_ff;
      ppm_in         = ppm_ff;
      rsp_kind_in    = rsp_kind_ff;
      rsp_ro_in      = rsp_ro_ff;
      rsp_ppm_in     = rsp_ppm_ff;
      rsp_sat_in     = rsp_sat_ff;
      div_req        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in = req_func;
               gas_in  = req_gas;
               if (req_func && !calibrated_ff) begin
                  state_in = ST_IDLE;
               end else if (req_sample == '0) begin
                  res_in = RES_MAX;
                  if (req_func) read_sat_in = 1'b1;
                  else calib_sat_in = 1'b1;
                  state_in = ST_ACCUM;
               end else if (32'(req_sample) >= 32'(ADC_FULL_SCALE)) begin
                  res_in   = '0;
                  state_in = ST_ACCUM;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = DIV_NUM_W'(RES_SCALE) *
                                  (DIV_NUM_W'(ADC_FULL_SCALE) - DIV_NUM_W'(req_sample));
                  div_req.den   = DIV_DEN_W'(req_sample);
                  state_in      = ST_RDIV;
               end
            end
         end
         ST_RDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > DIV_NUM_W'(RES_MAX)) begin
                  res_in = RES_MAX;
                  if (func_ff) read_sat_in = 1'b1;
                  else calib_sat_in = 1'b1;
               end else begin
                  res_in = div_rsp.quot[RES_W-1:0];
               end
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (func_ff) begin
               read_count_in = count_new;
               read_sum_in   = sum_new;
            end else begin
               calib_count_in = count_new;
               calib_sum_in   = sum_new;
            end
            if (count_new >= tgt) begin
               div_req.start = 1'b1;
               div_req.num   = DIV_NUM_W'(sum_new);
               div_req.den   = DIV_DEN_W'(count_new);
               state_in      = ST_AVG;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_AVG: begin
            if (div_rsp.done) begin
               if (!func_ff) begin
                  if (caf_ff == '0) begin
                     ro_in         = Q24_MAX;
                     calib_sat_in  = 1'b1;
                     calibrated_in = 1'b1;
                     state_in      = ST_DONE;
                  end else begin
                     div_req.start = 1'b1;
                     div_req.num   = DIV_NUM_W'({avg, 8'b0});
                     div_req.den   = DIV_DEN_W'(caf_ff);
                     state_in      = ST_RODIV;
                  end
               end else begin
                  if (ro_ff == '0) begin
                     norm_in     = Q24_MAX;
                     read_sat_in = 1'b1;
                     state_in    = ST_RCHK;
                  end else begin
                     div_req.start = 1'b1;
                     div_req.num   = DIV_NUM_W'({avg, 16'b0});
                     div_req.den   = ro_ff;
                     state_in      = ST_RATDIV;
                  end
               end
            end
         end
         ST_RODIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > DIV_NUM_W'(Q24_MAX)) begin
                  ro_in        = Q24_MAX;
                  calib_sat_in = 1'b1;
               end else begin
                  ro_in = div_rsp.quot[RO_W-1:0];
               end
               calibrated_in = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_RATDIV: begin
            if (div_rsp.done) begin
               if (div_rsp.quot > DIV_NUM_W'(Q24_MAX)) begin
                  norm_in     = Q24_MAX;
                  read_sat_in = 1'b1;
               end else begin
                  norm_in = div_rsp.quot[RO_W-1:0];
               end
               state_in = ST_RCHK;
            end
         end
         ST_RCHK: begin
            if (gas_ff == GAS_NONE || cslope == '0) begin
               ppm_in   = '0;
               state_in = ST_DONE;
            end else begin
               if (norm_ff == '0) norm_in = RO_W'(1);
               msb_in   = 5'd23;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!norm_ff[RO_W-1] && msb_ff != '0) begin
               norm_in = {norm_ff[RO_W-2:0], 1'b0};
               msb_in  = msb_ff - 1'b1;
            end else begin
               state_in = ST_LOG1;
            end
         end
         ST_LOG1: begin
            l2_in    = $signed({lexp, 16'b0}) + $signed({4'b0, linterp});
            state_in = ST_LOG2;
         end
         ST_LOG2: begin
            l10_in   = l10_prod[35:16];
            state_in = ST_EGO;
         end
         ST_EGO: begin
            eneg_in       = ydiff[20] ^ cslope[15];
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(emag);
            div_req.den   = DIV_DEN_W'(smag);
            state_in      = ST_EDIV;
         end
         ST_EDIV: begin
            if (div_rsp.done) begin
               if (e35 > 35'sd4194303) e_in = 23'sh3FFFFF;
               else if (e35 < -35'sd4194304) e_in = 23'sh400000;
               else e_in = e35[22:0];
               state_in = ST_EXP1;
            end
         end
         ST_EXP1: begin
            t_in     = t_prod[40:16];
            state_in = ST_EXP2;
         end
         ST_EXP2: begin
            v_in     = einterp;
            state_in = ST_EXP3;
         end
         ST_EXP3: begin
            if (kexp >= 9'sd16) begin
               ppm_in      = '1;
               read_sat_in = 1'b1;
            end else if (kexp <= -9'sd24) begin
               ppm_in = '0;
            end else if (pshift > TAB_W'(16'hFFFF)) begin
               ppm_in      = '1;
               read_sat_in = 1'b1;
            end else begin
               ppm_in = pshift[PPM_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = func_ff;
               rsp_ro_in    = ro_ff;
               rsp_ppm_in   = func_ff ? ppm_ff : '0;
               rsp_sat_in   = func_ff ? read_sat_ff : calib_sat_ff;
               if (func_ff) begin
                  read_count_in = '0;
                  read_sum_in   = '0;
                  read_sat_in   = 1'b0;
               end else begin
                  calib_count_in = '0;
                  calib_sum_in   = '0;
                  calib_sat_in   = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         calib_count_ff <= '0;
         calib_sum_ff   <= '0;
         read_count_ff  <= '0;
         read_sum_ff    <= '0;
         ro_ff          <= RO_W'(2560);
         calibrated_ff  <= 1'b0;
         calib_sat_ff   <= 1'b0;
         read_sat_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         calib_tgt_ff   <= CNT_W'(50);
         read_tgt_ff    <= CNT_W'(50);
         caf_ff         <= 16'd2517;
         lpg_ff         <= 48'd40462943320187;
         co_ff          <= 48'd40463080225423;
         smoke_ff       <= 48'd40463029238006;
      end else begin
         state_ff       <= state_in;
         calib_count_ff <= calib_count_in;
         calib_sum_ff   <= calib_sum_in;
         read_count_ff  <= read_count_in;
         read_sum_ff    <= read_sum_in;
         ro_ff          <= ro_in;
         calibrated_ff  <= calibrated_in;
         calib_sat_ff   <= calib_sat_in;
         read_sat_ff    <= read_sat_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_CALIB_TGT: calib_tgt_ff <= csr_wdata[CNT_W-1:0];
               CSR_READ_TGT:  read_tgt_ff  <= csr_wdata[CNT_W-1:0];
               CSR_CAF:       caf_ff       <= csr_wdata[15:0];
               CSR_LPG:       lpg_ff       <= csr_wdata;
               CSR_CO:        co_ff        <= csr_wdata;
               CSR_SMOKE:     smoke_ff     <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      gas_ff      <= gas_in;
      res_ff      <= res_in;
      norm_ff     <= norm_in;
      msb_ff      <= msb_in;
      l2_ff       <= l2_in;
      l10_ff      <= l10_in;
      eneg_ff     <= eneg_in;
      e_ff        <= e_in;
      t_ff        <= t_in;
      v_ff        <= v_in;
      ppm_ff      <= ppm_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ro_ff   <= rsp_ro_in;
      rsp_ppm_ff  <= rsp_ppm_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_ro_kohm   = rsp_ro_ff;
   assign rsp_ppm       = rsp_ppm_ff;
   assign rsp_saturated = rsp_sat_ff;

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff &&
         $stable({rsp_kind_ff, rsp_ro_ff, rsp_ppm_ff, rsp_sat_ff}))
      else $error("result beat dropped or changed while waiting");

   a_calibrated_sticky: assert property (@(posedge clock) disable iff (reset)
      calibrated_ff |=> calibrated_ff) else $error("calibrated flag cleared");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result beat raised outside the done state");

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Testbench for gas_sensor_ppm_estimator_unit: directed and random sample runs,
// each result checked against an in-bench fixed-point estimate of Ro and ppm.
// Depends on gsp_pkg and the unit under test.
`timescale 1ns / 100ps
`default_nettype none

module tb_top import gsp_pkg::*; ();

   localparam logic FUNC_CAL  = 1'b0;
   localparam logic FUNC_MEAS = 1'b1;
   localparam logic [1:0] GAS_LPG   = 2'd0;
   localparam logic [1:0] GAS_CO    = 2'd1;
   localparam logic [1:0] GAS_SMK   = 2'd2;
   localparam logic [1:0] GAS_NONE  = 2'd3;
   localparam logic [2:0] REG_CALIB_TGT = 3'd0;
   localparam logic [2:0] REG_READ_TGT  = 3'd1;
   localparam logic [2:0] REG_CAF       = 3'd2;
   localparam logic [2:0] REG_LPG       = 3'd3;
   localparam logic [2:0] REG_CO        = 3'd4;
   localparam logic [2:0] REG_SMOKE     = 3'd5;
   localparam logic [47:0] LPG_DEFAULT   = 48'd40462943320187;
   localparam logic [47:0] CO_DEFAULT    = 48'd40463080225423;
   localparam logic [47:0] SMOKE_DEFAULT = 48'd40463029238006;
   localparam int SETTLE_CYCLES = 250;
   localparam int NSEG = 64;

   typedef struct {
      logic            kind;
      logic [RO_W-1:0] ro;
      logic [PPM_W-1:0] ppm;
      logic            sat;
   } estimate_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   wire                 req_ready;
   logic                req_func = 1'b0;
   logic [SAMPLE_W-1:0] req_sample = '0;
   logic [1:0]          req_gas = '0;
   wire                 rsp_valid;
   logic                rsp_ready = 1'b0;
   wire                 rsp_kind;
   wire [RO_W-1:0]      rsp_ro_kohm;
   wire [PPM_W-1:0]     rsp_ppm;
   wire                 rsp_saturated;
   logic                csr_write_en = 1'b0;
   logic [2:0]          csr_index = '0;
   logic [47:0]         csr_wdata = '0;

   gas_sensor_ppm_estimator_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and configuration copy
   longint unsigned log_lut [0:NSEG];
   longint unsigned exp_lut [0:NSEG];
   int unsigned     calib_tgt, read_tgt, caf;
   logic [47:0]     curve [3];
   int unsigned     calib_cnt, read_cnt;
   longint unsigned calib_acc, read_acc;
   longint unsigned ro_reg;
   bit              cal_done, calib_clip, read_clip;

   estimate_type pending_results [$];
   int  fail_count = 0;
   bit  idle_en = 1'b1;
   bit  stall_en = 1'b1;
   int  hold_req = 0;
   int  stall_left = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bv;
      res = 0;
      bv = 64'd1 << 62;
      while (bv > v) bv = bv >> 2;
      while (bv != 0) begin
         if (v >= res + bv) begin
            v = v - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   initial begin : build_luts
      longint unsigned roots [20];
      longint unsigned m, r, acc, f20;
      roots[0] = int_sqrt(64'd2 << 60);
      for (int b = 1; b < 20; b++) roots[b] = int_sqrt(roots[b-1] << 30);
      for (int i = 0; i < NSEG; i++) begin
         m = (64'd1 << 30) + ((64'(i) << 30) / NSEG);
         r = 0;
         for (int b = 0; b < 20; b++) begin
            m = (m * m) >> 30;
            r = r << 1;
            if (m >= (64'd2 << 30)) begin
               m = m >> 1;
               r = r | 1;
            end
         end
         log_lut[i] = (r + 8) >> 4;
         f20 = (64'(i) << 20) / NSEG;
         acc = 64'd1 << 30;
         for (int b = 0; b < 20; b++)
            if ((f20 >> (19 - b)) & 1) acc = (acc * roots[b]) >> 30;
         exp_lut[i] = (acc + 8192) >> 14;
      end
      log_lut[NSEG] = 65536;
      exp_lut[NSEG] = 131072;
   end

   function automatic longint lut_interp(bit use_exp, longint unsigned f);
      longint unsigned pos, i, fr, a, b;
      pos = (f & 16'hFFFF) * NSEG;
      i = pos >> 16;
      fr = pos & 16'hFFFF;
      a = use_exp ? exp_lut[i] : log_lut[i];
      b = use_exp ? exp_lut[i+1] : log_lut[i+1];
      return longint'(a + (((b - a) * fr) >> 16));
   endfunction

   function automatic longint unsigned sensor_res(int unsigned s, inout bit clip);
      if (s == 0) begin
         clip = 1'b1;
         return 64'h3FFFFF;
      end
      if (s >= ADC_FULL_SCALE) return 0;
      return (64'd1280 * (ADC_FULL_SCALE - s)) / s;
   endfunction

   function automatic logic [15:0] curve_ppm(longint unsigned ratio, logic [47:0] crv,
                                             inout bit clip);
      longint x, y, slope, l2, l10, e, t, k, v;
      longint unsigned f;
      int msb;
      x = longint'($signed(crv[47:32]));
      y = longint'($signed(crv[31:16]));
      slope = longint'($signed(crv[15:0]));
      if (slope == 0) return 0;
      if (ratio == 0) ratio = 1;
      msb = 23;
      while (msb > 0 && ((ratio >> msb) & 1) == 0) msb--;
      f = (msb >= 16) ? (ratio >> (msb - 16)) : (ratio << (16 - msb));
      l2 = longint'(msb - 16) * 65536 + lut_interp(1'b0, f);
      l10 = (l2 * 19728) >>> 16;
      e = ((l10 - 16 * y) * 4096) / slope + 16 * x;
      t = (e * 217707) >>> 16;
      k = t >>> 16;
      v = lut_interp(1'b1, longint'(t - k * 65536));
      if (k >= 16) begin
         clip = 1'b1;
         return 16'hFFFF;
      end
      if (16 - k >= 40) return 0;
      v = v >> (16 - k);
      if (v > 65535) begin
         clip = 1'b1;
         return 16'hFFFF;
      end
      return v[15:0];
   endfunction

   function automatic void estimate_step(logic func, logic [SAMPLE_W-1:0] s, logic [1:0] gas);
      estimate_type est;
      longint unsigned avg, q;
      int unsigned tgt;
      if (func == FUNC_CAL) begin
         tgt = (calib_tgt == 0) ? 1 : calib_tgt;
         calib_acc += sensor_res(s, calib_clip);
         calib_cnt++;
         if (calib_cnt < tgt) return;
         avg = calib_acc / calib_cnt;
         if (caf == 0) begin
            q = 64'hFFFFFF;
            calib_clip = 1'b1;
         end else begin
            q = (avg << 8) / caf;
         end
         if (q > 64'hFFFFFF) begin
            q = 64'hFFFFFF;
            calib_clip = 1'b1;
         end
         ro_reg = q;
         cal_done = 1'b1;
         est.kind = FUNC_CAL;
         est.ro = ro_reg[23:0];
         est.ppm = '0;
         est.sat = calib_clip;
         pending_results.push_back(est);
         calib_cnt = 0;
         calib_acc = 0;
         calib_clip = 1'b0;
      end else begin
         tgt = (read_tgt == 0) ? 1 : read_tgt;
         if (!cal_done) return;
         read_acc += sensor_res(s, read_clip);
         read_cnt++;
         if (read_cnt < tgt) return;
         avg = read_acc / read_cnt;
         if (ro_reg == 0) begin
            q = 64'hFFFFFF;
            read_clip = 1'b1;
         end else begin
            q = (avg << 16) / ro_reg;
         end
         if (q > 64'hFFFFFF) begin
            q = 64'hFFFFFF;
            read_clip = 1'b1;
         end
         est.kind = FUNC_MEAS;
         est.ro = ro_reg[23:0];
         est.ppm = (gas == GAS_NONE) ? 16'd0 : curve_ppm(q, curve[gas], read_clip);
         est.sat = read_clip;
         pending_results.push_back(est);
         read_cnt = 0;
         read_acc = 0;
         read_clip = 1'b0;
      end
   endfunction

   // receiver: check each beat, then decide ready for the next edge
   always @(posedge clock) begin
      estimate_type est;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result beat kind %0d ppm %0d", rsp_kind, rsp_ppm);
            fail_count++;
         end else begin
            est = pending_results.pop_front();
            if (rsp_kind !== est.kind) begin
               $error("kind exp %0d got %0d", est.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_ro_kohm !== est.ro) begin
               $error("ro_kohm exp %0d got %0d", est.ro, rsp_ro_kohm);
               fail_count++;
            end
            if (rsp_ppm !== est.ppm) begin
               $error("ppm exp %0d got %0d", est.ppm, rsp_ppm);
               fail_count++;
            end
            if (rsp_saturated !== est.sat) begin
               $error("saturated exp %0d got %0d", est.sat, rsp_saturated);
               fail_count++;
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (hold_req > 0) begin
         stall_left = hold_req - 1;
         hold_req = 0;
         rsp_ready <= 1'b0;
      end else if (stall_en && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(logic func, logic [SAMPLE_W-1:0] s, logic [1:0] gas);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_sample <= s;
      req_gas <= gas;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      estimate_step(func, s, gas);
   endtask

   task automatic send_random(int n, int cal_pct);
      logic [SAMPLE_W-1:0] s;
      repeat (n) begin
         case ($urandom_range(0, 9))
            0: s = 11'd0;
            1: s = (($urandom_range(0, 1)) != 0) ? 11'd2047 : 11'd1;
            default: s = SAMPLE_W'($urandom_range(0, 2047));
         endcase
         send_beat(($urandom_range(0, 99) < cal_pct) ? FUNC_CAL : FUNC_MEAS, s,
                   2'($urandom_range(0, 3)));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [2:0] idx, logic [47:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_CALIB_TGT: calib_tgt = v[7:0];
         REG_READ_TGT:  read_tgt = v[7:0];
         REG_CAF:       caf = v[15:0];
         REG_LPG:       curve[0] = v;
         REG_CO:        curve[1] = v;
         REG_SMOKE:     curve[2] = v;
         default: ;
      endcase
   endtask

   function automatic logic [47:0] random_curve();
      logic [15:0] sl;
      if ($urandom_range(0, 4) == 0) return {16'($urandom), 32'($urandom)};
      sl = -16'($urandom_range(1, 4096));
      return {16'($urandom_range(0, 16384)), 16'($urandom_range(0, 8192)), sl};
   endfunction

   task automatic test_uncalibrated();
      send_beat(FUNC_MEAS, 11'd500, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd0, GAS_CO);
      send_beat(FUNC_MEAS, 11'd2047, GAS_NONE);
      settle();
   endtask

   task automatic test_directed();
      csr_write(REG_CALIB_TGT, 48'd1);
      csr_write(REG_READ_TGT, 48'd1);
      // zero sample clips, full scale gives zero Ro
      send_beat(FUNC_CAL, 11'd0, GAS_LPG);
      send_beat(FUNC_CAL, 11'd2047, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd300, GAS_LPG);
      send_beat(FUNC_CAL, 11'd1000, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd1000, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd800, GAS_CO);
      send_beat(FUNC_MEAS, 11'd1500, GAS_SMK);
      send_beat(FUNC_MEAS, 11'd1000, GAS_NONE);
      send_beat(FUNC_MEAS, 11'd2047, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd1, GAS_CO);
      send_beat(FUNC_MEAS, 11'd0, GAS_SMK);
      settle();
      csr_write(REG_CAF, 48'd0);
      csr_write(REG_LPG, 48'h1000_0000_0000);
      csr_write(REG_CALIB_TGT, 48'd0);
      send_beat(FUNC_CAL, 11'd1024, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd1024, GAS_LPG);
      settle();
      // lower the target in the middle of a run
      csr_write(REG_CAF, 48'd2517);
      csr_write(REG_CALIB_TGT, 48'd3);
      csr_write(REG_READ_TGT, 48'd4);
      send_beat(FUNC_CAL, 11'd900, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd700, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd600, GAS_LPG);
      settle();
      csr_write(REG_CALIB_TGT, 48'd1);
      csr_write(REG_READ_TGT, 48'd1);
      send_beat(FUNC_CAL, 11'd1100, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd400, GAS_CO);
      settle();
      csr_write(REG_LPG, 48'hFFFF_FFFF_FFFF);
      csr_write(REG_CO, LPG_DEFAULT);
      send_beat(FUNC_MEAS, 11'd50, GAS_LPG);
      send_beat(FUNC_MEAS, 11'd20, GAS_CO);
      settle();
   endtask

   task automatic test_random_sweep();
      for (int ph = 0; ph < 7; ph++) begin
         settle();
         case (ph)
            0: begin
               csr_write(REG_CALIB_TGT, 48'd255);
               csr_write(REG_READ_TGT, 48'd255);
               csr_write(REG_CAF, 48'd65535);
            end
            1: begin
               csr_write(REG_CALIB_TGT, 48'd1);
               csr_write(REG_READ_TGT, 48'd1);
               csr_write(REG_CAF, 48'd1);
            end
            default: begin
               csr_write(REG_CALIB_TGT, 48'($urandom_range(1, 4)));
               csr_write(REG_READ_TGT, 48'($urandom_range(1, 5)));
               csr_write(REG_CAF, ($urandom_range(0, 5) == 0) ? 48'd65535 :
                                  48'($urandom_range(256, 8000)));
            end
         endcase
         csr_write(REG_LPG, (ph == 2) ? LPG_DEFAULT : random_curve());
         csr_write(REG_CO, (ph == 2) ? CO_DEFAULT : random_curve());
         csr_write(REG_SMOKE, (ph == 2) ? SMOKE_DEFAULT : random_curve());
         if (ph == 0) send_random(300, 85);
         else send_random(130, 30);
      end
      settle();
   endtask

   task automatic test_backpressure();
      csr_write(REG_CALIB_TGT, 48'd1);
      csr_write(REG_READ_TGT, 48'd1);
      hold_req = 400;
      send_random(30, 40);
      settle();
   endtask

   task automatic test_drain_pause();
      send_random(10, 30);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      send_random(10, 30);
      settle();
   endtask

   task automatic test_no_idle();
      idle_en = 1'b0;
      stall_en = 1'b0;
      csr_write(REG_READ_TGT, 48'd2);
      send_random(100, 30);
   endtask

   initial begin
      calib_tgt = 50;
      read_tgt = 50;
      caf = 2517;
      curve[0] = LPG_DEFAULT;
      curve[1] = CO_DEFAULT;
      curve[2] = SMOKE_DEFAULT;
      calib_cnt = 0;
      read_cnt = 0;
      calib_acc = 0;
      read_acc = 0;
      ro_reg = 2560;
      cal_done = 1'b0;
      calib_clip = 1'b0;
      read_clip = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_uncalibrated();
      test_directed();
      test_random_sweep();
      test_backpressure();
      test_drain_pause();
      test_no_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[gas_sensor_ppm_estimator_unit] OK");
      end else begin
         $display("[gas_sensor_ppm_estimator_unit] ERROR");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("[gas_sensor_ppm_estimator_unit] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
